// ----- src/lfu_pkg.sv -----
// Shared types and constants of the LFU cache with LRU tie-break.
// Used by lfu_cell and by the top level lfu_cache_lru_tiebreak.
package lfu_pkg;

   localparam int CAPACITY   = 16;
   localparam int IDX_BITS   = 4;
   localparam int COUNT_BITS = 16;
   localparam int KEY_BITS   = 32;
   localparam int DATA_BITS  = 32;
   localparam int OCC_BITS   = 5;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // Commands broadcast to every cell.
   localparam logic [1:0] CMD_NONE    = 2'd0;
   localparam logic [1:0] CMD_PROMOTE = 2'd1;
   localparam logic [1:0] CMD_INSERT  = 2'd2;

   // Operations carried by a request.
   localparam logic FUNC_GET = 1'b0;
   localparam logic FUNC_PUT = 1'b1;

   typedef struct packed {
      logic [1:0]           op;
      logic [IDX_BITS-1:0]  slot;
      logic [IDX_BITS-1:0]  ref_rank;
      logic                 wr_data;
      logic                 evict;
      logic [KEY_BITS-1:0]  key;
      logic [DATA_BITS-1:0] data;
   } cmd_type;

   // Victim candidate handed from cell to cell.
   typedef struct packed {
      logic                  vld;
      logic [COUNT_BITS-1:0] count;
      logic [IDX_BITS-1:0]   rank;
      logic [IDX_BITS-1:0]   idx;
   } cand_type;

endpackage

// ----- src/lfu_cell.sv -----
// One cache entry: key, data, use count and recency rank, plus one stage
// of the victim search chain. Depends on lfu_pkg.
module lfu_cell
   import lfu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [IDX_BITS-1:0]   cell_idx,
   input  cmd_type               cmd,
   input  cand_type              cand_in,
   output cand_type              cand_out,
   output logic                  match,
   output logic                  valid,
   output logic [IDX_BITS-1:0]   rank,
   output logic [DATA_BITS-1:0]  data
);

   logic                  valid_ff, valid_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [DATA_BITS-1:0]  data_ff, data_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [IDX_BITS-1:0]   rank_ff, rank_in;
   cand_type              cand_ff, cand_in_next;
   logic                  sel;

   assign sel      = (cmd.slot == cell_idx);
   assign match    = valid_ff && (key_ff == cmd.key);
   assign valid    = valid_ff;
   assign rank     = rank_ff;
   assign data     = data_ff;
   assign cand_out = cand_ff;

   // Entry update for promote and insert commands.
   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      data_in  = data_ff;
      count_in = count_ff;
      rank_in  = rank_ff;
      case (cmd.op)
         CMD_PROMOTE: begin
            if (sel) begin
               rank_in = '0;
               if (count_ff != COUNT_MAX) begin
                  count_in = count_ff + 1'b1;
               end
               if (cmd.wr_data) begin
                  data_in = cmd.data;
               end
            end else if (valid_ff && rank_ff < cmd.ref_rank) begin
               rank_in = rank_ff + 1'b1;
            end
         end
         CMD_INSERT: begin
            if (sel) begin
               valid_in = 1'b1;
               key_in   = cmd.key;
               data_in  = cmd.data;
               count_in = '0;
               rank_in  = '0;
            end else if (valid_ff) begin
               // Removal of a younger victim cancels the aging step.
               if (!(cmd.evict && rank_ff > cmd.ref_rank)) begin
                  rank_in = rank_ff + 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Keep the better of the incoming candidate and this entry.
   always_comb begin
      cand_in_next = cand_in;
      if (valid_ff && (!cand_in.vld || count_ff < cand_in.count ||
          (count_ff == cand_in.count && rank_ff > cand_in.rank))) begin
         cand_in_next.vld   = 1'b1;
         cand_in_next.count = count_ff;
         cand_in_next.rank  = rank_ff;
         cand_in_next.idx   = cell_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         count_ff <= '0;
         rank_ff  <= '0;
         cand_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
         rank_ff  <= rank_in;
         cand_ff  <= cand_in_next;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      data_ff <= data_in;
   end

endmodule

// ----- src/lfu_cache_lru_tiebreak.sv -----
// Top level of the LFU cache with LRU tie-break: control sequencer, the
// row of lfu_cell entries and the response register. Depends on lfu_pkg.
//
// Usage: a request on req_ carries a get or put (req_tuser) with key and
// value in req_tdata. Each request yields exactly one response on rsp_
// with the hit flag, the read value and the eviction flag.
// The cells compare the key in parallel. A hit, a get miss or a put that
// finds a free slot goes from the lookup state to the done state, which
// loads the response register and returns the sequencer to idle. A put
// to a full cache first runs the victim search, which walks the row of
// cells one cell per cycle, and then the eviction state, which replaces
// the victim with the new entry. One request is handled at a time;
// req_tready is high only while the sequencer is idle.
// A finished response waits in the output register while a new request
// may already be accepted; if the receiver stalls, the next result holds
// in the sequencer until the register frees.
// Reset clears all entries, the occupancy and sets capacity_in_use to 10.
// csr_wr_en writes capacity_in_use; write it only while the block is idle.
module lfu_cache_lru_tiebreak
   import lfu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data,   // capacity_in_use
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,     // [31:0] lookup_key, [63:32] store_value
   input  logic        req_tuser,     // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata      // [0] hit, [32:1] read_value, [33] evicted
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_LOOK  = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_EVICT = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic                  func_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [DATA_BITS-1:0]  val_ff;
   logic [OCC_BITS-1:0]   cap_ff, occ_ff, occ_in, eff_cap;
   logic [IDX_BITS:0]     scan_ff, scan_in;
   logic                  res_hit_ff, res_hit_in, res_evict_ff, res_evict_in;
   logic [DATA_BITS-1:0]  res_data_ff, res_data_in;
   logic                  rsp_valid_ff;
   logic                  rsp_hit_ff, rsp_evict_ff;
   logic [DATA_BITS-1:0]  rsp_data_ff;
   logic                  load_rsp;

   cmd_type               cmd;
   cand_type              chain [CAPACITY+1];
   logic [CAPACITY-1:0]   match_v, valid_v;
   logic [IDX_BITS-1:0]   rank_v [CAPACITY];
   logic [DATA_BITS-1:0]  data_v [CAPACITY];
   logic                  found, free_any;
   logic [IDX_BITS-1:0]   found_idx, free_idx;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_evict_ff, rsp_data_ff, rsp_hit_ff};
   assign load_rsp   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   // Out-of-range capacity values are clamped.
   always_comb begin
      eff_cap = cap_ff;
      if (cap_ff == '0) begin
         eff_cap = OCC_BITS'(1);
      end else if (cap_ff > OCC_BITS'(CAPACITY)) begin
         eff_cap = OCC_BITS'(CAPACITY);
      end
   end

   // Row of entry cells; the candidate chain starts empty.
   assign chain[0] = '0;
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      lfu_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (IDX_BITS'(g)),
         .cmd      (cmd),
         .cand_in  (chain[g]),
         .cand_out (chain[g+1]),
         .match    (match_v[g]),
         .valid    (valid_v[g]),
         .rank     (rank_v[g]),
         .data     (data_v[g])
      );
   end

   // Hit index and lowest free slot.
   always_comb begin
      found     = 1'b0;
      found_idx = '0;
      free_any  = 1'b0;
      free_idx  = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (match_v[i]) begin
            found     = 1'b1;
            found_idx = IDX_BITS'(i);
         end
         if (!valid_v[i]) begin
            free_any = 1'b1;
            free_idx = IDX_BITS'(i);
         end
      end
   end

   // Sequencer and cell commands.
   always_comb begin
      state_in     = state_ff;
      occ_in       = occ_ff;
      scan_in      = scan_ff;
      res_hit_in   = res_hit_ff;
      res_evict_in = res_evict_ff;
      res_data_in  = res_data_ff;
      cmd          = '0;
      cmd.op       = CMD_NONE;
      cmd.key      = key_ff;
      cmd.data     = val_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            res_hit_in   = 1'b0;
            res_evict_in = 1'b0;
            res_data_in  = '0;
            state_in     = ST_DONE;
            if (found) begin
               cmd.op       = CMD_PROMOTE;
               cmd.slot     = found_idx;
               cmd.ref_rank = rank_v[found_idx];
               cmd.wr_data  = (func_ff == FUNC_PUT);
               res_hit_in   = 1'b1;
               if (func_ff == FUNC_GET) begin
                  res_data_in = data_v[found_idx];
               end
            end else if (func_ff == FUNC_PUT) begin
               if (occ_ff >= eff_cap || !free_any) begin
                  state_in = ST_SCAN;
                  scan_in  = '0;
               end else begin
                  cmd.op   = CMD_INSERT;
                  cmd.slot = free_idx;
                  occ_in   = occ_ff + 1'b1;
               end
            end
         end
         ST_SCAN: begin
            scan_in = scan_ff + 1'b1;
            if (scan_ff == (IDX_BITS+1)'(CAPACITY - 1)) begin
               state_in = ST_EVICT;
            end
         end
         ST_EVICT: begin
            cmd.op       = CMD_INSERT;
            cmd.slot     = chain[CAPACITY].idx;
            cmd.ref_rank = chain[CAPACITY].rank;
            cmd.evict    = 1'b1;
            res_evict_in = 1'b1;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         cap_ff       <= OCC_BITS'(10);
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
         scan_ff  <= scan_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Request capture and result payload.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         func_ff <= req_tuser;
         key_ff  <= req_tdata[31:0];
         val_ff  <= req_tdata[63:32];
      end
      res_hit_ff   <= res_hit_in;
      res_evict_ff <= res_evict_in;
      res_data_ff  <= res_data_in;
      if (load_rsp) begin
         rsp_hit_ff   <= res_hit_ff;
         rsp_evict_ff <= res_evict_ff;
         rsp_data_ff  <= res_data_ff;
      end
   end

   // Occupancy tracks the valid entries and stays within the row.
   assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_BITS'(CAPACITY))
      else $error("occupancy above capacity");

   assert property (@(posedge clock) disable iff (reset)
      $countones(valid_v) == int'(occ_ff))
      else $error("occupancy differs from valid entries");

   // The victim search always ends on a valid entry.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EVICT |-> chain[CAPACITY].vld && valid_v[chain[CAPACITY].idx])
      else $error("eviction without a valid victim");

   // An accepted request goes straight to the lookup.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == ST_LOOK)
      else $error("accepted request not looked up");

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the LFU cache with LRU tie-break.
// Drives random get/put requests and capacity writes; a scoreboard class models the cache.
// Depends on lfu_pkg and the top level lfu_cache_lru_tiebreak.
module tb
   import lfu_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // Cache model and queue of expected responses.
   class cache_scoreboard;
      bit                  valid [CAPACITY];
      bit [KEY_BITS-1:0]   keys [CAPACITY];
      bit [DATA_BITS-1:0]  vals [CAPACITY];
      bit [COUNT_BITS-1:0] uses [CAPACITY];
      int                  rank [CAPACITY];
      int                  occ;
      int                  cap_reg;
      bit [33:0]           pending_rsp [$];
      int                  mismatches;

      function void clear();
         for (int i = 0; i < CAPACITY; i++) begin
            valid[i] = 0; keys[i] = 0; vals[i] = 0; uses[i] = 0; rank[i] = 0;
         end
         occ = 0;
         cap_reg = 10;
         mismatches = 0;
      endfunction

      function int eff_cap();
         if (cap_reg < 1) return 1;
         if (cap_reg > CAPACITY) return CAPACITY;
         return cap_reg;
      endfunction

      function void touch(int e);
         for (int i = 0; i < CAPACITY; i++)
            if (valid[i] && i != e && rank[i] < rank[e]) rank[i]++;
         rank[e] = 0;
         if (uses[e] != COUNT_MAX) uses[e]++;
      endfunction

      function void drop(int e);
         valid[e] = 0;
         for (int i = 0; i < CAPACITY; i++)
            if (valid[i] && rank[i] > rank[e]) rank[i]--;
         if (occ > 0) occ--;
      endfunction

      function int pick_victim();
         int v;
         v = -1;
         for (int i = 0; i < CAPACITY; i++) begin
            if (!valid[i]) continue;
            if (v < 0 || uses[i] < uses[v] || (uses[i] == uses[v] && rank[i] > rank[v]))
               v = i;
         end
         return v;
      endfunction

      // Note an accepted request and queue the response it must produce.
      function void note_request(bit func, bit [31:0] key, bit [31:0] val);
         int found, slot;
         bit ev;
         bit [31:0] rd;
         found = -1; slot = -1; ev = 0; rd = 0;
         for (int i = 0; i < CAPACITY; i++)
            if (found < 0 && valid[i] && keys[i] == key) found = i;
         if (found >= 0) begin
            if (func == FUNC_GET) rd = vals[found];
            else vals[found] = val;
            touch(found);
            pending_rsp.push_back({1'b0, rd, 1'b1});
            return;
         end
         if (func == FUNC_GET) begin
            pending_rsp.push_back('0);
            return;
         end
         if (occ >= eff_cap()) begin
            slot = pick_victim();
            if (slot >= 0) begin drop(slot); ev = 1; end
         end
         if (slot < 0)
            for (int i = 0; i < CAPACITY; i++)
               if (slot < 0 && !valid[i]) slot = i;
         if (slot < 0) begin
            slot = pick_victim();
            if (slot < 0) slot = 0;
            drop(slot);
            ev = 1;
         end
         for (int i = 0; i < CAPACITY; i++)
            if (valid[i]) rank[i]++;
         valid[slot] = 1; keys[slot] = key; vals[slot] = val;
         uses[slot] = 0; rank[slot] = 0;
         occ++;
         pending_rsp.push_back({ev, 32'd0, 1'b0});
      endfunction

      // Compare one response with the oldest expectation.
      function void check_response(bit [39:0] got);
         bit [33:0] exp_rsp;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected response %h", got);
            return;
         end
         exp_rsp = pending_rsp.pop_front();
         if (got[0] !== exp_rsp[0] || got[32:1] !== exp_rsp[32:1] || got[33] !== exp_rsp[33]) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Mismatch: hit %b/%b read_value %h/%h evicted %b/%b (exp/got)",
                        exp_rsp[0], got[0], exp_rsp[32:1], got[32:1], exp_rsp[33], got[33]);
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_wr_en = 0;
   logic [4:0]  csr_wr_data = '0;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        req_tuser = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [39:0] rsp_tdata;

   cache_scoreboard board = new();
   bit  calm_send, calm_recv, hold_recv, hold_taken;
   int  hold_cycles;
   bit [31:0] key_pool [8];

   lfu_cache_lru_tiebreak i_dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // Send one request, with an optional random gap before it. The valid
   // stays high after acceptance until the next gap or idle point.
   task send_request(input bit func, input bit [31:0] key, input bit [31:0] val);
      while (!calm_send && $urandom_range(99) < 14) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= func;
      req_tdata  <= {val, key};
      do @(posedge clock); while (!req_tready);
      board.note_request(func, key, val);
   endtask

   // Stop offering requests.
   task stop_requests();
      req_tvalid <= 0;
   endtask

   // Write the capacity register once everything has drained.
   task write_capacity(input bit [4:0] cap);
      stop_requests();
      while (board.pending_rsp.size() != 0) @(posedge clock);
      repeat (25) @(posedge clock);
      csr_wr_en   <= 1;
      csr_wr_data <= cap;
      @(posedge clock);
      board.cap_reg = cap;
      csr_wr_en <= 0;
   endtask

   function bit [31:0] pick_key();
      if ($urandom_range(9) < 8) return key_pool[$urandom_range(7)];
      return $urandom;
   endfunction

   // Receiver: random stalls plus a long hold-off when asked.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) board.check_response(rsp_tdata);
         if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_tready  <= 0;
         end else if (hold_recv && !hold_taken) begin
            hold_cycles <= 300;
            hold_taken  <= 1;
            rsp_tready  <= 0;
         end else begin
            rsp_tready <= calm_recv || ($urandom_range(99) >= 14);
         end
      end
   end

   initial begin
      #20_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      bit [4:0] caps [6];
      board.clear();
      caps = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd3, 5'd17};
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: extreme keys and values, get miss, put hit, get hit.
      send_request(FUNC_GET, 32'h8000_0000, 32'h0);
      send_request(FUNC_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(FUNC_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      send_request(FUNC_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(FUNC_PUT, 32'h0, 32'h0);
      send_request(FUNC_GET, 32'h7FFF_FFFF, $urandom);
      send_request(FUNC_PUT, 32'h8000_0000, 32'h5555_AAAA);
      send_request(FUNC_GET, 32'h8000_0000, 32'h0);
      // Fill past the reset capacity so evictions start.
      for (int i = 0; i < 12; i++) send_request(FUNC_PUT, 32'h100 + i, i);
      // Lower the capacity below occupancy.
      write_capacity(5'd2);
      for (int i = 0; i < 4; i++) send_request(FUNC_PUT, 32'h200 + i, $urandom);

      // Random phases over several capacity settings.
      for (int ph = 0; ph < 6; ph++) begin
         write_capacity(caps[ph]);
         for (int i = 0; i < 8; i++) key_pool[i] = $urandom;
         calm_send = (ph == 2);
         calm_recv = (ph == 2);
         if (ph == 3) hold_recv = 1;
         for (int n = 0; n < 105; n++)
            send_request(1'($urandom_range(1)), pick_key(), $urandom);
         // Pause until every response has come back.
         if (ph == 4) begin
            stop_requests();
            while (board.pending_rsp.size() != 0) @(posedge clock);
         end
      end

      // Drain and finish.
      stop_requests();
      while (board.pending_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (board.mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule
